[rtl/srfr_pkg.sv]
// ----------------------------------------------------------------------------
// srfr_pkg
// Shared types, codes and constants of the serial request frame responder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package srfr_pkg;

   // default sizes
   localparam int RX_BUFFER_BYTES_DEF = 64;
   localparam int MAX_FRAME_BYTES_DEF = 10;

   // request command field codes
   localparam logic [1:0] REQ_BYTE   = 2'd0;
   localparam logic [1:0] REQ_IDLE   = 2'd1;
   localparam logic [1:0] REQ_SAMPLE = 2'd2;

   // result outcome codes
   localparam logic [2:0] OUT_DROP   = 3'd0;
   localparam logic [2:0] OUT_SENSOR = 3'd1;
   localparam logic [2:0] OUT_LOG    = 3'd2;
   localparam logic [2:0] OUT_DEVICE = 3'd3;
   localparam logic [2:0] OUT_ERROR  = 3'd4;

   // error reply codes
   localparam logic [7:0] ERR_NONE   = 8'd0;
   localparam logic [7:0] ERR_HEADER = 8'd1;
   localparam logic [7:0] ERR_LEN    = 8'd2;
   localparam logic [7:0] ERR_CMD    = 8'd3;
   localparam logic [7:0] ERR_CRC    = 8'd4;

   // frame bytes
   localparam logic [7:0] HDR_FIRST      = 8'hAA;
   localparam logic [7:0] HDR_SECOND     = 8'h55;
   localparam logic [7:0] CMD_SENSOR     = 8'h01;
   localparam logic [7:0] CMD_LOG        = 8'h02;
   localparam logic [7:0] LEN_SHORT_REQ  = 8'h01;
   localparam logic [7:0] LEN_LOG_REQ    = 8'h05;
   localparam logic [7:0] RSP_SENSOR_CMD = 8'h81;
   localparam logic [7:0] RSP_SENSOR_LEN = 8'h05;
   localparam logic [7:0] RSP_ERROR_CMD  = 8'hE0;
   localparam logic [7:0] RSP_ERROR_LEN  = 8'h02;
   localparam logic [7:0] OPCODE_RESET   = 8'h03;

   // CRC-16/Modbus
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // length checks and transmit buffer
   localparam int         CMP_W          = 9;
   localparam logic [8:0] MIN_FRAME      = 9'd6;
   localparam logic [8:0] FRAME_OVERHEAD = 9'd5;
   localparam int         TX_BYTES       = 10;
   localparam int         TX_IDX_W       = 4;
   localparam logic [3:0] TX_ERROR_BYTES  = 4'd7;
   localparam logic [3:0] TX_SENSOR_BYTES = 4'd10;
   localparam logic [3:0] CRC_FIRST_IDX   = 4'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_CRC_RX,
      ST_CRC_CMP,
      ST_CRC_TX,
      ST_TX_FIN,
      ST_EMIT,
      ST_NOTE
   } srfr_state_type;

   typedef struct packed {
      logic init;
      logic step;
   } crc_ctl_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  rx_byte;
      logic [15:0] sample_number;
      logic [11:0] adc_reading;
   } req_item_type;

   typedef struct packed {
      logic [7:0]  tx_byte;
      logic        tx_valid;
      logic        last;
      logic [2:0]  outcome;
      logic [31:0] query_sequence;
   } rsp_item_type;

endpackage

[rtl/srfr_crc.sv]
// ----------------------------------------------------------------------------
// srfr_crc
// Shared CRC-16/Modbus unit, one byte per cycle into a running register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srfr_crc (
   input  logic                     clock,
   input  srfr_pkg::crc_ctl_type    crc_ctl,
   input  logic [7:0]               crc_data,
   output logic [15:0]              crc_value
);

   logic [15:0] crc_ff;
   logic [15:0] crc_in;

   function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] d);
      logic [15:0] r;
      r = c ^ {8'h00, d};
      for (int b = 0; b < 8; b++) begin
         r = r[0] ? ((r >> 1) ^ srfr_pkg::CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction

   always_comb begin
      crc_in = crc_ff;
      if (crc_ctl.init) begin
         crc_in = srfr_pkg::CRC_INIT;
      end else if (crc_ctl.step) begin
         crc_in = crc_byte(crc_ff, crc_data);
      end
   end

   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
   end

   assign crc_value = crc_ff;

endmodule

[rtl/serial_request_frame_responder_unit.sv]
// ----------------------------------------------------------------------------
// serial_request_frame_responder_unit
// Byte, sample and configuration items: ready again at once.
// Idle item: a check step, then, unless the frame is dropped, a CRC pass over the
// LEN+1 bytes from LEN on and a compare (both skipped on a header, length or
// command error), then for a reply a CRC pass over 3 or 6 bytes, a finish step
// and 7 or 10 result items, which can stall; other outcomes give one result item.
// Synchronous active-high reset clears store, count, sample, result valid; opcode 3.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module serial_request_frame_responder_unit #(
   parameter int RX_BUFFER_BYTES = srfr_pkg::RX_BUFFER_BYTES_DEF,
   parameter int MAX_FRAME_BYTES = srfr_pkg::MAX_FRAME_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  srfr_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output srfr_pkg::rsp_item_type rsp_item,
   input  logic                   csr_write_enable,
   input  logic [7:0]             csr_write_data
);

   localparam int CNT_W = $clog2(RX_BUFFER_BYTES + 1);
   localparam int SIX_W = $clog2(MAX_FRAME_BYTES);

   // sequencer
   srfr_pkg::srfr_state_type state_ff, state_in;

   // receive side
   logic [CNT_W-1:0] count_ff;
   logic [7:0]       store_ff [MAX_FRAME_BYTES];
   logic [15:0]      number_ff;
   logic [11:0]      reading_ff;
   logic [7:0]       opcode_ff;

   // transmit side
   logic [7:0]                    tx_buf_ff [srfr_pkg::TX_BYTES];
   logic [srfr_pkg::TX_IDX_W-1:0] tx_len_ff;
   logic [srfr_pkg::TX_IDX_W-1:0] idx_ff, idx_in;
   logic [2:0]                    outcome_ff;
   logic [31:0]                   seq_ff;
   logic                          rsp_valid_ff;
   srfr_pkg::rsp_item_type        rsp_item_ff;

   // CRC unit
   srfr_pkg::crc_ctl_type crc_ctl;
   logic [7:0]            crc_data;
   logic [15:0]           crc_value;

   // decodes
   logic                         accept;
   logic                         out_free;
   logic [7:0]                   len_b, cmd_b;
   logic [srfr_pkg::CMP_W-1:0]   cnt_ext, len_ext;
   logic                         frame_drop;
   logic [7:0]                   check_code;
   logic [15:0]                  recv_crc;
   logic                         crc_match;
   logic                         rx_crc_done, tx_crc_done, emit_last;
   logic                         store_we, count_inc;

   // sequencer outputs
   logic       build_err, build_sensor, crc_fin;
   logic [7:0] reply_code;
   logic       note_set, note_load, emit_load, frame_clear;
   logic [2:0] note_outcome;
   logic [31:0] note_seq;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign store_we  = accept && (req_item.command == srfr_pkg::REQ_BYTE) &&
                      (count_ff < CNT_W'(MAX_FRAME_BYTES));
   assign count_inc = accept && (req_item.command == srfr_pkg::REQ_BYTE) &&
                      (count_ff < CNT_W'(RX_BUFFER_BYTES));

   // Length gate and header / command checks, all on fixed store places.
   assign len_b   = store_ff[2];
   assign cmd_b   = store_ff[3];
   assign cnt_ext = srfr_pkg::CMP_W'(count_ff);
   assign len_ext = {1'b0, len_b} + srfr_pkg::FRAME_OVERHEAD;

   assign frame_drop = (cnt_ext < srfr_pkg::MIN_FRAME) ||
                       (cnt_ext > srfr_pkg::CMP_W'(MAX_FRAME_BYTES)) ||
                       (cnt_ext != len_ext);

   always_comb begin
      if (store_ff[0] != srfr_pkg::HDR_FIRST || store_ff[1] != srfr_pkg::HDR_SECOND) begin
         check_code = srfr_pkg::ERR_HEADER;
      end else if (cmd_b == srfr_pkg::CMD_SENSOR) begin
         check_code = (len_b != srfr_pkg::LEN_SHORT_REQ) ? srfr_pkg::ERR_LEN
                                                         : srfr_pkg::ERR_NONE;
      end else if (cmd_b == srfr_pkg::CMD_LOG) begin
         check_code = (len_b != srfr_pkg::LEN_LOG_REQ) ? srfr_pkg::ERR_LEN
                                                       : srfr_pkg::ERR_NONE;
      end else if (cmd_b == opcode_ff) begin
         check_code = (len_b != srfr_pkg::LEN_SHORT_REQ) ? srfr_pkg::ERR_LEN
                                                         : srfr_pkg::ERR_NONE;
      end else begin
         check_code = srfr_pkg::ERR_CMD;
      end
   end

   // Past the checks LEN is 1 or 5, so the received CRC sits at 4/5 or 8/9.
   assign recv_crc  = (len_b == srfr_pkg::LEN_LOG_REQ) ? {store_ff[9], store_ff[8]}
                                                       : {store_ff[5], store_ff[4]};
   assign crc_match = (crc_value == recv_crc);

   assign rx_crc_done = (idx_ff == srfr_pkg::CRC_FIRST_IDX + srfr_pkg::TX_IDX_W'(len_b));
   assign tx_crc_done = (idx_ff == tx_len_ff - 4'd3);
   assign emit_last   = (idx_ff == tx_len_ff - 4'd1);

   // One byte a cycle into the CRC unit: stored frame while checking,
   // transmit buffer while building a reply.
   assign crc_data = (state_ff == srfr_pkg::ST_CRC_RX) ? store_ff[SIX_W'(idx_ff)]
                                                       : tx_buf_ff[idx_ff];

   srfr_crc u_crc (
      .clock     (clock),
      .crc_ctl   (crc_ctl),
      .crc_data  (crc_data),
      .crc_value (crc_value)
   );

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         srfr_pkg::ST_IDLE: begin
            if (accept && req_item.command == srfr_pkg::REQ_IDLE) begin
               state_in = srfr_pkg::ST_CHECK;
            end
         end
         srfr_pkg::ST_CHECK: begin
            if (frame_drop) begin
               state_in = srfr_pkg::ST_NOTE;
            end else if (check_code != srfr_pkg::ERR_NONE) begin
               state_in = srfr_pkg::ST_CRC_TX;
            end else begin
               state_in = srfr_pkg::ST_CRC_RX;
            end
         end
         srfr_pkg::ST_CRC_RX: begin
            if (rx_crc_done) begin
               state_in = srfr_pkg::ST_CRC_CMP;
            end
         end
         srfr_pkg::ST_CRC_CMP: begin
            if (!crc_match || cmd_b == srfr_pkg::CMD_SENSOR) begin
               state_in = srfr_pkg::ST_CRC_TX;
            end else begin
               state_in = srfr_pkg::ST_NOTE;
            end
         end
         srfr_pkg::ST_CRC_TX: begin
            if (tx_crc_done) begin
               state_in = srfr_pkg::ST_TX_FIN;
            end
         end
         srfr_pkg::ST_TX_FIN: begin
            state_in = srfr_pkg::ST_EMIT;
         end
         srfr_pkg::ST_EMIT: begin
            if (out_free && emit_last) begin
               state_in = srfr_pkg::ST_IDLE;
            end
         end
         srfr_pkg::ST_NOTE: begin
            if (out_free) begin
               state_in = srfr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = srfr_pkg::ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------- sequencer outputs
   always_comb begin
      req_ready    = 1'b0;
      crc_ctl      = '0;
      idx_in       = idx_ff;
      build_err    = 1'b0;
      build_sensor = 1'b0;
      reply_code   = srfr_pkg::ERR_NONE;
      crc_fin      = 1'b0;
      note_set     = 1'b0;
      note_outcome = srfr_pkg::OUT_DROP;
      note_seq     = '0;
      note_load    = 1'b0;
      emit_load    = 1'b0;
      frame_clear  = 1'b0;
      unique case (state_ff)
         srfr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         srfr_pkg::ST_CHECK: begin
            if (frame_drop) begin
               note_set     = 1'b1;
               note_outcome = srfr_pkg::OUT_DROP;
            end else begin
               crc_ctl.init = 1'b1;
               idx_in       = srfr_pkg::CRC_FIRST_IDX;
               if (check_code != srfr_pkg::ERR_NONE) begin
                  build_err  = 1'b1;
                  reply_code = check_code;
               end
            end
         end
         srfr_pkg::ST_CRC_RX: begin
            crc_ctl.step = 1'b1;
            idx_in       = idx_ff + 4'd1;
         end
         srfr_pkg::ST_CRC_CMP: begin
            if (!crc_match) begin
               build_err    = 1'b1;
               reply_code   = srfr_pkg::ERR_CRC;
               crc_ctl.init = 1'b1;
               idx_in       = srfr_pkg::CRC_FIRST_IDX;
            end else if (cmd_b == srfr_pkg::CMD_SENSOR) begin
               build_sensor = 1'b1;
               crc_ctl.init = 1'b1;
               idx_in       = srfr_pkg::CRC_FIRST_IDX;
            end else if (cmd_b == srfr_pkg::CMD_LOG) begin
               note_set     = 1'b1;
               note_outcome = srfr_pkg::OUT_LOG;
               note_seq     = {store_ff[4], store_ff[5], store_ff[6], store_ff[7]};
            end else begin
               note_set     = 1'b1;
               note_outcome = srfr_pkg::OUT_DEVICE;
            end
         end
         srfr_pkg::ST_CRC_TX: begin
            crc_ctl.step = 1'b1;
            idx_in       = idx_ff + 4'd1;
         end
         srfr_pkg::ST_TX_FIN: begin
            crc_fin = 1'b1;
            idx_in  = '0;
         end
         srfr_pkg::ST_EMIT: begin
            if (out_free) begin
               emit_load   = 1'b1;
               idx_in      = idx_ff + 4'd1;
               frame_clear = emit_last;
            end
         end
         srfr_pkg::ST_NOTE: begin
            if (out_free) begin
               note_load   = 1'b1;
               frame_clear = 1'b1;
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // ------------------------------------------------------------------ registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srfr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
   end

   // frame store and byte count, emptied after every idle item
   always_ff @(posedge clock) begin
      if (reset || frame_clear) begin
         count_ff <= '0;
         for (int i = 0; i < MAX_FRAME_BYTES; i++) begin
            store_ff[i] <= '0;
         end
      end else begin
         if (store_we) begin
            store_ff[count_ff[SIX_W-1:0]] <= req_item.rx_byte;
         end
         if (count_inc) begin
            count_ff <= count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         number_ff  <= '0;
         reading_ff <= '0;
      end else if (accept && req_item.command == srfr_pkg::REQ_SAMPLE) begin
         number_ff  <= req_item.sample_number;
         reading_ff <= req_item.adc_reading;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         opcode_ff <= srfr_pkg::OPCODE_RESET;
      end else if (csr_write_enable) begin
         opcode_ff <= csr_write_data;
      end
   end

   // reply frame assembly; CRC bytes land in the last two places
   always_ff @(posedge clock) begin
      if (build_err) begin
         tx_buf_ff[0] <= srfr_pkg::HDR_FIRST;
         tx_buf_ff[1] <= srfr_pkg::HDR_SECOND;
         tx_buf_ff[2] <= srfr_pkg::RSP_ERROR_LEN;
         tx_buf_ff[3] <= srfr_pkg::RSP_ERROR_CMD;
         tx_buf_ff[4] <= reply_code;
         tx_len_ff    <= srfr_pkg::TX_ERROR_BYTES;
      end else if (build_sensor) begin
         tx_buf_ff[0] <= srfr_pkg::HDR_FIRST;
         tx_buf_ff[1] <= srfr_pkg::HDR_SECOND;
         tx_buf_ff[2] <= srfr_pkg::RSP_SENSOR_LEN;
         tx_buf_ff[3] <= srfr_pkg::RSP_SENSOR_CMD;
         tx_buf_ff[4] <= number_ff[15:8];
         tx_buf_ff[5] <= number_ff[7:0];
         tx_buf_ff[6] <= {4'h0, reading_ff[11:8]};
         tx_buf_ff[7] <= reading_ff[7:0];
         tx_len_ff    <= srfr_pkg::TX_SENSOR_BYTES;
      end else if (crc_fin) begin
         tx_buf_ff[tx_len_ff - 4'd2] <= crc_value[7:0];
         tx_buf_ff[tx_len_ff - 4'd1] <= crc_value[15:8];
      end
   end

   always_ff @(posedge clock) begin
      if (build_err) begin
         outcome_ff <= srfr_pkg::OUT_ERROR;
      end else if (build_sensor) begin
         outcome_ff <= srfr_pkg::OUT_SENSOR;
      end else if (note_set) begin
         outcome_ff <= note_outcome;
         seq_ff     <= note_seq;
      end
   end

   // output register: parts the sequencer from the result channel
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_load || note_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_load) begin
         rsp_item_ff.tx_byte        <= tx_buf_ff[idx_ff];
         rsp_item_ff.tx_valid       <= 1'b1;
         rsp_item_ff.last           <= emit_last;
         rsp_item_ff.outcome        <= outcome_ff;
         rsp_item_ff.query_sequence <= '0;
      end else if (note_load) begin
         rsp_item_ff.tx_byte        <= '0;
         rsp_item_ff.tx_valid       <= 1'b0;
         rsp_item_ff.last           <= 1'b1;
         rsp_item_ff.outcome        <= outcome_ff;
         rsp_item_ff.query_sequence <= seq_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

[rtl/srfr_checker.sv]
// ----------------------------------------------------------------------------
// srfr_checker
// Port-level checks on the result channel of the frame responder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srfr_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input srfr_pkg::rsp_item_type rsp_item
);

   // nothing pending right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // stalled item holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("result item changed while stalled");

   // notices are single, final and carry no byte
   a_notice: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.tx_valid |-> rsp_item.last && rsp_item.tx_byte == 8'h00)
      else $error("notice not final or carries a byte");

   // frame bytes only come from sensor or error replies
   a_frame_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.tx_valid |->
         rsp_item.outcome == srfr_pkg::OUT_SENSOR || rsp_item.outcome == srfr_pkg::OUT_ERROR)
      else $error("frame byte with wrong outcome");

   // sequence number only on log requests
   a_sequence: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.outcome != srfr_pkg::OUT_LOG |-> rsp_item.query_sequence == '0)
      else $error("sequence number outside a log request");

endmodule

bind serial_request_frame_responder_unit srfr_checker u_srfr_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_item  (rsp_item)
);

[tb/srfr_checker.sv]
// ----------------------------------------------------------------------------
// srfr_scoreboard
// Passive scoreboard for the frame responder: it models each accepted item
// and compares every result item against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package srfr_tb_crc_pkg;

   // one byte through CRC-16/Modbus, LSB first
   function automatic logic [15:0] crc16_modbus_byte(input logic [15:0] crc_in,
                                                     input logic [7:0]  data);
      logic [15:0] crc;
      crc = crc_in ^ {8'h00, data};
      for (int b = 0; b < 8; b++) begin
         if (crc[0]) crc = (crc >> 1) ^ srfr_pkg::CRC_POLY;
         else        crc = crc >> 1;
      end
      return crc;
   endfunction

endpackage

module srfr_scoreboard (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  srfr_pkg::req_item_type req_item,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  srfr_pkg::rsp_item_type rsp_item,
   input  logic                   csr_write_enable,
   input  logic [7:0]             csr_write_data,
   output int                     pending_count,
   output int                     mismatch_count,
   output int                     checked_count
);
   import srfr_pkg::*;
   import srfr_tb_crc_pkg::*;

   localparam int RX_LIMIT    = RX_BUFFER_BYTES_DEF;
   localparam int FRAME_LIMIT = MAX_FRAME_BYTES_DEF;

   logic [7:0]   frame_bytes [0:FRAME_LIMIT-1];
   int           byte_total;
   logic [15:0]  sample_no;
   logic [11:0]  sample_adc;
   logic [7:0]   info_opcode;
   logic [7:0]   reply_bytes [0:TX_BYTES-1];
   rsp_item_type awaited_replies [$];
   int           fails = 0;
   int           checked = 0;

   function automatic rsp_item_type reply_item(input logic [7:0]  b,
                                               input logic        vld,
                                               input logic        lst,
                                               input logic [2:0]  oc,
                                               input logic [31:0] seq);
      rsp_item_type r;
      r.tx_byte        = b;
      r.tx_valid       = vld;
      r.last           = lst;
      r.outcome        = oc;
      r.query_sequence = seq;
      return r;
   endfunction

   task automatic clear_frame();
      for (int i = 0; i < FRAME_LIMIT; i++) frame_bytes[i] = 8'h00;
      byte_total = 0;
   endtask

   // appends the CRC of reply_bytes[2..n-3] and queues the n bytes
   task automatic queue_reply(input int n, input logic [2:0] oc);
      logic [15:0] crc;
      crc = CRC_INIT;
      for (int i = 2; i < n - 2; i++) crc = crc16_modbus_byte(crc, reply_bytes[i]);
      reply_bytes[n-2] = crc[7:0];
      reply_bytes[n-1] = crc[15:8];
      for (int k = 0; k < n; k++)
         awaited_replies.push_back(reply_item(reply_bytes[k], 1'b1, k == n - 1, oc, '0));
   endtask

   task automatic answer_idle();
      logic [7:0]  len;
      logic [7:0]  cmd;
      logic [7:0]  code;
      logic [15:0] crc;
      len = frame_bytes[2];
      cmd = frame_bytes[3];
      if (byte_total < int'(MIN_FRAME) || byte_total > FRAME_LIMIT ||
          byte_total != int'(len) + int'(FRAME_OVERHEAD)) begin
         awaited_replies.push_back(reply_item(8'h00, 1'b0, 1'b1, OUT_DROP, '0));
      end else begin
         code = ERR_NONE;
         if (frame_bytes[0] != HDR_FIRST || frame_bytes[1] != HDR_SECOND) begin
            code = ERR_HEADER;
         end else if (cmd == CMD_LOG) begin
            if (len != LEN_LOG_REQ) code = ERR_LEN;
         end else if (cmd == CMD_SENSOR || cmd == info_opcode) begin
            if (len != LEN_SHORT_REQ) code = ERR_LEN;
         end else begin
            code = ERR_CMD;
         end
         if (code == ERR_NONE) begin
            crc = CRC_INIT;
            for (int i = 0; i <= int'(len); i++)
               crc = crc16_modbus_byte(crc, frame_bytes[2+i]);
            if (crc != {frame_bytes[4+len], frame_bytes[3+len]}) code = ERR_CRC;
         end
         if (code != ERR_NONE) begin
            reply_bytes[0] = HDR_FIRST;
            reply_bytes[1] = HDR_SECOND;
            reply_bytes[2] = RSP_ERROR_LEN;
            reply_bytes[3] = RSP_ERROR_CMD;
            reply_bytes[4] = code;
            queue_reply(int'(TX_ERROR_BYTES), OUT_ERROR);
         end else if (cmd == CMD_SENSOR) begin
            reply_bytes[0] = HDR_FIRST;
            reply_bytes[1] = HDR_SECOND;
            reply_bytes[2] = RSP_SENSOR_LEN;
            reply_bytes[3] = RSP_SENSOR_CMD;
            reply_bytes[4] = sample_no[15:8];
            reply_bytes[5] = sample_no[7:0];
            reply_bytes[6] = {4'h0, sample_adc[11:8]};
            reply_bytes[7] = sample_adc[7:0];
            queue_reply(int'(TX_SENSOR_BYTES), OUT_SENSOR);
         end else if (cmd == CMD_LOG) begin
            awaited_replies.push_back(reply_item(8'h00, 1'b0, 1'b1, OUT_LOG,
               {frame_bytes[4], frame_bytes[5], frame_bytes[6], frame_bytes[7]}));
         end else begin
            awaited_replies.push_back(reply_item(8'h00, 1'b0, 1'b1, OUT_DEVICE, '0));
         end
      end
      clear_frame();
   endtask

   task automatic track_request(input req_item_type it);
      case (it.command)
         REQ_BYTE: begin
            if (byte_total < FRAME_LIMIT) frame_bytes[byte_total] = it.rx_byte;
            if (byte_total < RX_LIMIT) byte_total++;
         end
         REQ_SAMPLE: begin
            sample_no  = it.sample_number;
            sample_adc = it.adc_reading;
         end
         REQ_IDLE: answer_idle();
         default: ;
      endcase
   endtask

   task automatic report_field(input string field, input logic [31:0] want_v,
                               input logic [31:0] got_v);
      fails++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want_v, got_v);
   endtask

   task automatic compare_reply();
      rsp_item_type want;
      if (awaited_replies.size() == 0) begin
         fails++;
         $display("%0t: unexpected result, expected none, got byte %h valid %b last %b",
                  $time, rsp_item.tx_byte, rsp_item.tx_valid, rsp_item.last);
         $display("%0t: unexpected result, outcome %0d seq %h",
                  $time, rsp_item.outcome, rsp_item.query_sequence);
      end else begin
         want = awaited_replies.pop_front();
         checked++;
         if (rsp_item.tx_byte !== want.tx_byte)
            report_field("tx_byte", 32'(want.tx_byte), 32'(rsp_item.tx_byte));
         if (rsp_item.tx_valid !== want.tx_valid)
            report_field("tx_valid", 32'(want.tx_valid), 32'(rsp_item.tx_valid));
         if (rsp_item.last !== want.last)
            report_field("last", 32'(want.last), 32'(rsp_item.last));
         if (rsp_item.outcome !== want.outcome)
            report_field("outcome", 32'(want.outcome), 32'(rsp_item.outcome));
         if (rsp_item.query_sequence !== want.query_sequence)
            report_field("query_sequence", want.query_sequence, rsp_item.query_sequence);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_frame();
         sample_no   = '0;
         sample_adc  = '0;
         info_opcode = OPCODE_RESET;
         awaited_replies.delete();
      end else begin
         if (rsp_valid && rsp_ready) compare_reply();
         if (csr_write_enable) info_opcode = csr_write_data;
         if (req_valid && req_ready) track_request(req_item);
      end
      pending_count  <= awaited_replies.size();
      mismatch_count <= fails;
      checked_count  <= checked;
   end

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the serial request frame responder. Sends sample
// updates, well-formed and damaged request frames and line noise, sweeps the
// device-info opcode, and relies on srfr_scoreboard for all result checking.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import srfr_pkg::*;
   import srfr_tb_crc_pkg::*;

   localparam int         ITEM_TARGET  = 180;
   localparam int         PHASES       = 6;
   localparam int         SETTLE_TICKS = 40;  // > worst-case idle turnaround
   localparam logic [1:0] REQ_UNUSED   = 2'd3;

   // damage applied to an otherwise well-formed request
   typedef enum int {
      FLAW_NONE,
      FLAW_HEADER,
      FLAW_LEN,
      FLAW_CMD,
      FLAW_CRC
   } flaw_type;

   logic         clock            = 1'b0;
   logic         reset            = 1'b1;
   logic         req_valid        = 1'b0;
   logic         req_ready;
   req_item_type req_item         = '0;
   logic         rsp_valid;
   logic         rsp_ready        = 1'b0;
   rsp_item_type rsp_item;
   logic         csr_write_enable = 1'b0;
   logic [7:0]   csr_write_data   = 8'h00;

   int pending_count;
   int mismatch_count;
   int checked_count;

   int items_sent    = 0;
   int idle_events   = 0;
   int opcode_writes = 0;
   int send_quiet    = 0;
   int take_quiet    = 0;

   logic [7:0] opcode_now;       // mirror of the opcode register
   logic [7:0] frame_buf [0:15]; // bytes of the next frame to send
   int         frame_size;

   always #2 clock = ~clock;

   serial_request_frame_responder_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_item         (req_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_item         (rsp_item),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   srfr_scoreboard u_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_item         (req_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_item         (rsp_item),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .pending_count    (pending_count),
      .mismatch_count   (mismatch_count),
      .checked_count    (checked_count)
   );

   // Pause before an item: mostly a random wait, with occasional runs of
   // back-to-back items so both busy and starved phases get exercised.
   function automatic int draw_pause(inout int quiet);
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         quiet = $urandom_range(4, 24);
         return 0;
      end
      return $urandom_range(0, 18);
   endfunction

   // Unused fields carry random junk so every input bit toggles.
   function automatic req_item_type noise_item(input logic [1:0] cmd);
      req_item_type it;
      it.command       = cmd;
      it.rx_byte       = 8'($urandom);
      it.sample_number = 16'($urandom);
      it.adc_reading   = 12'($urandom);
      return it;
   endfunction

   // Returns at the edge that accepted the item; valid stays high so a
   // zero-gap follower needs just one assignment in that step.
   task automatic send_item(input req_item_type it);
      int gap;
      gap = draw_pause(send_quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (!req_ready);
      if (it.command != REQ_UNUSED) items_sent++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      req_item_type it;
      it         = noise_item(REQ_BYTE);
      it.rx_byte = b;
      send_item(it);
   endtask

   task automatic send_idle();
      send_item(noise_item(REQ_IDLE));
      idle_events++;
   endtask

   task automatic send_sample(input logic [15:0] num, input logic [11:0] adc);
      req_item_type it;
      it               = noise_item(REQ_SAMPLE);
      it.sample_number = num;
      it.adc_reading   = adc;
      send_item(it);
   endtask

   // random sample, biased toward the field extremes
   task automatic send_random_sample();
      case ($urandom_range(0, 3))
         0:       send_sample(16'h0000, 12'h000);
         1:       send_sample(16'hFFFF, 12'hFFF);
         default: send_sample(16'($urandom), 12'($urandom));
      endcase
   endtask

   // AA 55 LEN CMD data.. crcL crcH; data bytes come from payload, MSB first
   task automatic build_request(input logic [7:0] cmd, input logic [7:0] len,
                                input logic [31:0] payload);
      logic [15:0] crc;
      frame_buf[0] = HDR_FIRST;
      frame_buf[1] = HDR_SECOND;
      frame_buf[2] = len;
      frame_buf[3] = cmd;
      for (int i = 0; i < int'(len) - 1; i++)
         frame_buf[4+i] = (i < 4) ? payload[31-8*i -: 8] : 8'($urandom);
      crc = CRC_INIT;
      for (int i = 2; i < 3 + int'(len); i++) crc = crc16_modbus_byte(crc, frame_buf[i]);
      frame_buf[3+len] = crc[7:0];
      frame_buf[4+len] = crc[15:8];
      frame_size = 5 + int'(len);
   endtask

   // Sends frame_buf then the idle item. With mix set, sample updates and
   // unused-command items land between bytes; neither disturbs the frame.
   task automatic send_frame(input bit mix);
      for (int i = 0; i < frame_size; i++) begin
         if (mix && $urandom_range(0, 11) == 0) send_random_sample();
         if (mix && $urandom_range(0, 19) == 0) send_item(noise_item(REQ_UNUSED));
         send_byte(frame_buf[i]);
      end
      send_idle();
   endtask

   function automatic logic [7:0] pick_command();
      case ($urandom_range(0, 2))
         0:       return CMD_SENSOR;
         1:       return CMD_LOG;
         default: return opcode_now;
      endcase
   endfunction

   // one request frame with random content and the given damage
   task automatic send_request(input flaw_type flaw);
      logic [7:0] cmd;
      logic [7:0] len;
      cmd = pick_command();
      len = (cmd == CMD_LOG) ? LEN_LOG_REQ : LEN_SHORT_REQ;
      if (flaw == FLAW_LEN) begin
         // swap the lengths so the byte count still agrees with LEN
         len = (cmd == CMD_LOG) ? LEN_SHORT_REQ : LEN_LOG_REQ;
      end else if (flaw == FLAW_CMD) begin
         do cmd = 8'($urandom); while (cmd == CMD_SENSOR || cmd == CMD_LOG || cmd == opcode_now);
         len = 8'($urandom_range(1, 5));
      end
      build_request(cmd, len, $urandom);
      if (flaw == FLAW_HEADER)
         frame_buf[$urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
      if (flaw == FLAW_CRC)
         frame_buf[frame_size - 1 - $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
      send_frame(1'b1);
   endtask

   // Line noise: short random bursts, sometimes with a plausible header or
   // a LEN that matches the count so the later checks get reached.
   task automatic send_noise_frame();
      frame_size = $urandom_range(0, 13);
      for (int i = 0; i < frame_size; i++) frame_buf[i] = 8'($urandom);
      if ($urandom_range(0, 1)) begin
         frame_buf[0] = HDR_FIRST;
         frame_buf[1] = HDR_SECOND;
      end
      if (frame_size >= 3 && $urandom_range(0, 1)) frame_buf[2] = 8'(frame_size - 5);
      send_frame(1'b1);
   endtask

   task automatic random_step();
      case ($urandom_range(0, 19))
         0, 1:    send_random_sample();
         11:      send_request(FLAW_HEADER);
         12:      send_request(FLAW_LEN);
         13:      send_request(FLAW_CMD);
         14:      send_request(FLAW_CRC);
         15, 16,
         17:      send_noise_frame();
         18:      send_item(noise_item(REQ_UNUSED));
         19: begin
            // stray bytes with no idle: they spoil the next frame's count
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
         end
         default: send_request(FLAW_NONE);
      endcase
   endtask

   // Opcode writes happen only with the block quiet: all results in, plus
   // enough cycles for the block to wind down its last idle event.
   task automatic set_opcode(input logic [7:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      opcode_now = value;
      opcode_writes++;
   endtask

   // result side: independent random stalls per result item
   initial begin : take_side
      int gap;
      do @(posedge clock); while (reset);
      forever begin
         gap = draw_pause(take_quiet);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin : stimulus
      logic [7:0] phase_opcode [0:PHASES-1];
      int         goal_base;
      phase_opcode[0] = 8'h00;
      phase_opcode[1] = 8'hFF;
      phase_opcode[2] = CMD_SENSOR;  // clash: sensor meaning must win
      phase_opcode[3] = CMD_LOG;     // clash: log meaning must win
      phase_opcode[4] = 8'($urandom);
      phase_opcode[5] = OPCODE_RESET;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      opcode_now = OPCODE_RESET;

      // directed: extreme sample, then one of each request kind
      send_sample(16'hFFFF, 12'hFFF);
      build_request(CMD_SENSOR, LEN_SHORT_REQ, '0);
      send_frame(1'b0);
      send_idle();                                // empty frame, dropped
      send_item(noise_item(REQ_UNUSED));
      build_request(CMD_LOG, LEN_LOG_REQ, 32'hFFFF_FFFF);
      send_frame(1'b0);
      build_request(OPCODE_RESET, LEN_SHORT_REQ, '0);
      send_frame(1'b0);

      // long frame: count saturates, frame dropped
      repeat (RX_BUFFER_BYTES_DEF + 6) send_byte(8'($urandom));
      send_idle();

      // random phases, each under its own opcode setting; the directed items
      // count toward the overall item budget
      goal_base = items_sent;
      for (int p = 0; p < PHASES; p++) begin
         set_opcode(phase_opcode[p]);
         while (items_sent < goal_base + (p + 1) * (ITEM_TARGET - goal_base) / PHASES)
            random_step();
         send_idle();                             // close any stray bytes
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);

      $display("Run covered %0d request items, %0d line-idle frame checks, %0d opcode settings",
               items_sent, idle_events, opcode_writes);
      $display("Result items compared: %0d", checked_count);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin : watchdog
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

[filelist.f]
rtl/srfr_pkg.sv
rtl/srfr_crc.sv
rtl/serial_request_frame_responder_unit.sv
rtl/srfr_checker.sv
tb/srfr_checker.sv
tb/tb_top.sv
